// ===== rtl/pid3_pkg.sv =====
package pid3_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int INTEGRAL_BITS = 32;
  localparam int DERIV_BITS    = 40;

  // raw error before saturation: roll/pitch sum of two commands minus sensed angle, yaw wrapped heading difference
  localparam int RAW_W = 18;

  localparam int NUM_AXES = 3;
  localparam int GAIN_W   = 48;
  localparam int DRIVE_W  = 16;

  // heading wrap constants, Q4.12
  localparam logic signed [RAW_W-1:0] Q_PI     = 18'sd12868;
  localparam logic signed [RAW_W-1:0] Q_TWO_PI = 18'sd25736;

  // configuration register indexes
  localparam logic [1:0] REG_GAINS_ROLL  = 2'd0;
  localparam logic [1:0] REG_GAINS_PITCH = 2'd1;
  localparam logic [1:0] REG_GAINS_YAW   = 2'd2;

  // axis lanes
  localparam int AX_ROLL  = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_YAW   = 2;

  typedef struct packed {
    logic start;
    logic clear;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic                      done;
    logic signed [DRIVE_W-1:0] drive;
  } lane_stat_t;

endpackage

// ===== rtl/pid3_lane.sv =====
module pid3_lane import pid3_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctrl_t              ctrl_i,
  input  logic signed [RAW_W-1:0] err_i,
  input  logic [15:0]             dt_i,
  input  logic [GAIN_W-1:0]       gains_i,
  output lane_stat_t              stat_o
);

  localparam int AW   = ANGLE_BITS;
  localparam int IW   = INTEGRAL_BITS;
  localparam int DW   = DERIV_BITS;
  localparam int QW   = AW + 17;          // |diff| << 16
  localparam int CW   = $clog2(QW + 1);
  localparam int SUMW = ((IW > DW) ? IW : DW) + 18;

  localparam logic signed [63:0] A_MAX = (64'sd1 <<< (AW - 1)) - 64'sd1;
  localparam logic signed [63:0] A_MIN = -A_MAX - 64'sd1;
  localparam logic signed [63:0] I_MAX = (64'sd1 <<< (IW - 1)) - 64'sd1;
  localparam logic signed [63:0] I_MIN = -I_MAX - 64'sd1;
  localparam logic signed [63:0] D_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam logic signed [63:0] D_MIN = -D_MAX - 64'sd1;
  localparam logic signed [SUMW-1:0] O_MAX = SUMW'(32767);
  localparam logic signed [SUMW-1:0] O_MIN = SUMW'(-32768);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]               state_q, state_d;
  logic [CW-1:0]            cnt_q;
  logic signed [IW-1:0]     integ_q;
  logic signed [AW-1:0]     prev_q;
  logic signed [AW-1:0]     e_q;
  logic                     neg_q;
  logic [15:0]              dt_q;
  logic [15:0]              rem_q;
  logic [QW-1:0]            quo_q;
  logic signed [AW+16:0]    edt_q;
  logic signed [DW-1:0]     d_q;
  logic signed [AW+15:0]    pkp_q;
  logic signed [IW+15:0]    pki_q;
  logic signed [DW+15:0]    pkd_q;
  logic signed [DRIVE_W-1:0] drive_q;

  logic signed [63:0]   err_w;
  logic signed [AW-1:0] e_sat;
  logic signed [AW:0]   diff;
  logic [AW:0]          mag;
  logic [16:0]          rem_sh;
  logic                 ge;
  logic [15:0]          rem_nx;
  logic signed [63:0]   q_s;
  logic signed [DW-1:0] d_sat;
  logic signed [63:0]   i_sum;
  logic signed [IW-1:0] i_sat;
  logic signed [SUMW-1:0] sum;
  logic signed [SUMW-1:0] sum_sh;
  logic signed [DRIVE_W-1:0] drv_sat;
  logic signed [15:0]   kp, ki, kd;

  assign kp = gains_i[15:0];
  assign ki = gains_i[31:16];
  assign kd = gains_i[47:32];

  always_comb begin
    err_w = 64'(err_i);
    if (err_w > A_MAX) begin
      e_sat = A_MAX[AW-1:0];
    end else if (err_w < A_MIN) begin
      e_sat = A_MIN[AW-1:0];
    end else begin
      e_sat = err_w[AW-1:0];
    end
    diff = {e_sat[AW-1], e_sat} - {prev_q[AW-1], prev_q};
    mag  = diff[AW] ? (~diff + 1'b1) : diff;
  end

  // restoring divide step, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[QW-1]};
    ge     = (rem_sh >= {1'b0, dt_q});
    rem_nx = ge ? 16'(rem_sh - {1'b0, dt_q}) : rem_sh[15:0];
  end

  always_comb begin
    q_s = neg_q ? -$signed(64'(quo_q)) : $signed(64'(quo_q));
    if (q_s > D_MAX) begin
      d_sat = D_MAX[DW-1:0];
    end else if (q_s < D_MIN) begin
      d_sat = D_MIN[DW-1:0];
    end else begin
      d_sat = q_s[DW-1:0];
    end
    i_sum = 64'(integ_q) + 64'(edt_q >>> 16);
    if (i_sum > I_MAX) begin
      i_sat = I_MAX[IW-1:0];
    end else if (i_sum < I_MIN) begin
      i_sat = I_MIN[IW-1:0];
    end else begin
      i_sat = i_sum[IW-1:0];
    end
  end

  always_comb begin
    sum    = SUMW'(pkp_q) + SUMW'(pki_q) + SUMW'(pkd_q);
    sum_sh = sum >>> 12;
    if (sum_sh > O_MAX) begin
      drv_sat = O_MAX[DRIVE_W-1:0];
    end else if (sum_sh < O_MIN) begin
      drv_sat = O_MIN[DRIVE_W-1:0];
    end else begin
      drv_sat = sum_sh[DRIVE_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (ctrl_i.start) begin
          state_d = ctrl_i.clear ? S_DONE : S_DIV;
        end
      end
      S_DIV:  if (cnt_q == CW'(1)) state_d = S_FIX;
      S_FIX:  state_d = S_MUL;
      S_MUL:  state_d = S_SUM;
      S_SUM:  state_d = S_DONE;
      S_DONE: if (ctrl_i.ack) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && ctrl_i.start) begin
        if (ctrl_i.clear) begin
          integ_q <= '0;
          prev_q  <= '0;
        end else begin
          prev_q <= e_sat;
          cnt_q  <= CW'(QW);
        end
      end
      if (state_q == S_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (state_q == S_FIX) begin
        integ_q <= i_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && ctrl_i.start) begin
      e_q     <= e_sat;
      neg_q   <= diff[AW];
      dt_q    <= dt_i;
      rem_q   <= '0;
      quo_q   <= {mag, 16'h0000};
      drive_q <= '0;
    end
    if (state_q == S_DIV) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[QW-2:0], ge};
      edt_q <= e_q * $signed({1'b0, dt_q});
    end
    if (state_q == S_FIX) begin
      d_q <= d_sat;
    end
    if (state_q == S_MUL) begin
      pkp_q <= kp * e_q;
      pki_q <= ki * integ_q;
      pkd_q <= kd * d_q;
    end
    if (state_q == S_SUM) begin
      drive_q <= drv_sat;
    end
  end

  assign stat_o.done  = (state_q == S_DONE);
  assign stat_o.drive = drive_q;

endmodule

// ===== rtl/pid3_merge.sv =====
module pid3_merge import pid3_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lane_stat_t                    stat_i [NUM_AXES],
  output logic                          ack_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [NUM_AXES*DRIVE_W-1:0]   m_axis_tdata
);

  logic                        valid_q;
  logic [NUM_AXES*DRIVE_W-1:0] data_q;
  logic                        all_done;

  assign all_done = stat_i[AX_ROLL].done & stat_i[AX_PITCH].done & stat_i[AX_YAW].done;
  assign ack_o    = all_done && (!valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ack_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack_o) begin
      data_q <= {stat_i[AX_YAW].drive, stat_i[AX_PITCH].drive, stat_i[AX_ROLL].drive};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

// ===== rtl/three_axis_pid_with_heading_wrap.sv =====
// Three-axis PID controller with heading wrap.
//
// Input stream: one request per control tick. s_axis_tdata carries the roll
// and pitch command pairs and sensed angles, heading target and sensed
// heading (Q3.12) and the tick interval (Q0.16 s); s_axis_tuser is the clear
// flag. Output stream: m_axis_tdata carries the roll, pitch and yaw drives
// (Q8.8, saturated). Gains are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// while the block is idle; writes to an index past the yaw gains are dropped.
//
// Three axis lanes run in lockstep. Each lane's derivative goes through a
// restoring divider that produces one quotient bit per cycle; a clear
// request skips the divider and goes straight to done. The input accepts
// one request at a time: s_axis_tready drops on acceptance and returns
// when the result is loaded into the output register, so a new request is
// taken only once the last one's result has left the lanes.
// If the receiver stalls, the lanes hold the finished result and the input
// stays blocked until the output register frees up; once the result is loaded
// there, a new request may be accepted while the output still waits.
// Reset clears gains, integrals, last errors and both handshakes.
module three_axis_pid_with_heading_wrap import pid3_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // roll_cmd_radio, roll_cmd_host, roll_sensed, pitch_cmd_radio,
  // pitch_cmd_host, pitch_sensed, heading_target, heading_sensed,
  // tick_interval, zero padding
  input  logic [143:0]                s_axis_tdata,
  // clear_state
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // drive_roll, drive_pitch, drive_yaw
  output logic [NUM_AXES*DRIVE_W-1:0] m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [GAIN_W-1:0]           cfg_wdata_i
);

  logic [GAIN_W-1:0]       gains_q [NUM_AXES];
  logic                    busy_q;
  logic                    accept;
  logic                    ack;
  lane_ctrl_t              ctrl;
  lane_stat_t              stat [NUM_AXES];
  logic signed [RAW_W-1:0] err [NUM_AXES];
  logic signed [RAW_W-1:0] yerr;
  logic [15:0]             dt;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q[AX_ROLL]  <= '0;
      gains_q[AX_PITCH] <= '0;
      gains_q[AX_YAW]   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAINS_ROLL:  gains_q[AX_ROLL]  <= cfg_wdata_i;
        REG_GAINS_PITCH: gains_q[AX_PITCH] <= cfg_wdata_i;
        REG_GAINS_YAW:   gains_q[AX_YAW]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (ack) begin
      busy_q <= 1'b0;
    end
  end

  // error formation; heading difference wrapped once into [-pi, pi]
  always_comb begin
    err[AX_ROLL]  = RAW_W'($signed(s_axis_tdata[15:0])) + RAW_W'($signed(s_axis_tdata[31:16]))
                  - RAW_W'($signed(s_axis_tdata[47:32]));
    err[AX_PITCH] = RAW_W'($signed(s_axis_tdata[63:48])) + RAW_W'($signed(s_axis_tdata[79:64]))
                  - RAW_W'($signed(s_axis_tdata[95:80]));
    yerr = RAW_W'($signed(s_axis_tdata[110:96])) - RAW_W'($signed(s_axis_tdata[125:111]));
    if (yerr > Q_PI) begin
      err[AX_YAW] = yerr - Q_TWO_PI;
    end else if (yerr < -Q_PI) begin
      err[AX_YAW] = yerr + Q_TWO_PI;
    end else begin
      err[AX_YAW] = yerr;
    end
    dt = (s_axis_tdata[141:126] == 16'd0) ? 16'd1 : s_axis_tdata[141:126];
  end

  assign ctrl.start = accept;
  assign ctrl.clear = s_axis_tuser;
  assign ctrl.ack   = ack;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    pid3_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .err_i   (err[g]),
      .dt_i    (dt),
      .gains_i (gains_q[g]),
      .stat_o  (stat[g])
    );
  end

  pid3_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stat_i        (stat),
    .ack_o         (ack),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/pid3_checker.sv =====
module pid3_checker import pid3_pkg::*; (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [NUM_AXES*DRIVE_W-1:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // one request in flight: ready drops after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after acceptance");

  // ready only drops because a request was taken
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input ready dropped without a request");

  // a new result only appears at the end of a request in flight
  a_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a request in flight");

endmodule

bind three_axis_pid_with_heading_wrap pid3_checker u_pid3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pid3_pkg::*;

  // index past the yaw gains, writes are dropped
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int NUM_DIR          = 24;
  localparam int FIRST_GAINED_ROW = 6;
  localparam int SETTLE_CYCLES    = 40;
  localparam int WATCHDOG_CYCLES  = 1000;

  // same order as s_axis_tdata, roll_radio in the lowest bits
  typedef struct packed {
    logic        [15:0] interval;
    logic signed [14:0] head_sensed;
    logic signed [14:0] head_target;
    logic signed [15:0] pitch_sensed;
    logic signed [15:0] pitch_host;
    logic signed [15:0] pitch_radio;
    logic signed [15:0] roll_sensed;
    logic signed [15:0] roll_host;
    logic signed [15:0] roll_radio;
  } tick_fields_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] yaw;
    logic signed [DRIVE_W-1:0] pitch;
    logic signed [DRIVE_W-1:0] roll;
  } drives_t;

  typedef struct {
    bit clr;
    int rr, rh, rs, pr, ph, ps, ht, hs, dt;
    bit typed;
    int w_roll, w_pitch, w_yaw;
  } dir_row_t;

  typedef enum {GAINS_EXTREME, GAINS_RANDOM, GAINS_SMALL, GAINS_UNITY} gain_style_e;

  logic                        clk_i;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  // roll radio/host/sensed, pitch radio/host/sensed, heading target/sensed,
  // interval, zero padding
  logic [143:0]                s_axis_tdata  = '0;
  // clear_state
  logic                        s_axis_tuser  = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  // drive roll, pitch, yaw
  logic [NUM_AXES*DRIVE_W-1:0] m_axis_tdata;
  logic                        cfg_we_i      = 1'b0;
  logic [1:0]                  cfg_idx_i     = '0;
  logic [GAIN_W-1:0]           cfg_wdata_i   = '0;

  // predictor state
  logic [GAIN_W-1:0] gain_reg [NUM_AXES] = '{default: '0};
  longint            integ    [NUM_AXES] = '{default: 0};
  longint            prev_err [NUM_AXES] = '{default: 0};

  drives_t pending_drives [$];
  int      mismatches   = 0;
  int      idle_pct     = 0;
  int      stall_pct    = 0;
  int      stuck_cycles = 0;
  string   axis_name [NUM_AXES] = '{"drive_roll", "drive_pitch", "drive_yaw"};

  // clr, roll radio/host/sensed, pitch radio/host/sensed, heading target/sensed,
  // interval, typed, expected roll/pitch/yaw
  dir_row_t dir_table [NUM_DIR] = '{
    // reset gains: every drive reads zero
    '{0,      0,      0,      0,      0,      0,      0,      0,      0,     0, 1, 0, 0, 0},
    '{0,  32767,  32767, -32768,  32767,  32767, -32768,  16383, -16384, 65535, 1, 0, 0, 0},
    '{0, -32768, -32768,  32767, -32768, -32768,  32767, -16384,  16383,     1, 1, 0, 0, 0},
    '{0,   1234,   -567,     89,  -2000,    100,   -300,  12868, -12868,  4096, 1, 0, 0, 0},
    '{1,  32767,  -1000,    555,   -777,    123,    -45,   9000,  -9000,  1000, 1, 0, 0, 0},
    '{0,    100,      0,      0,    -50,      0,      0,     10,      0,   256, 1, 0, 0, 0},
    // gains loaded from here on
    '{0,   1024,      0,    512,  -1024,    256,      0,   1000,  -1000,  4096, 0, 0, 0, 0},
    '{0,   2048,      0,    512,   -512,    256,      0,   1200,   -800,     0, 0, 0, 0, 0},
    '{1,      0,      0,      0,      0,      0,      0,      0,      0,     0, 1, 0, 0, 0},
    '{0,  32767,  32767, -32768,  32767,  32767, -32768,  16383, -16384, 65535, 0, 0, 0, 0},
    '{0, -32768, -32768,  32767, -32768, -32768,  32767, -16384,  16383, 65535, 0, 0, 0, 0},
    '{0,      0,      0,      0,      0,      0,      0,  12868, -12868,    65, 0, 0, 0, 0},
    '{0,      0,      0,      0,      0,      0,      0, -12868,  12868,    65, 0, 0, 0, 0},
    '{0,      0,      0,      0,      0,      0,      0,  12868,      0,    65, 0, 0, 0, 0},
    '{0,      0,      0,      0,      0,      0,      0, -12868,      0,    65, 0, 0, 0, 0},
    '{0,      0,      0,      0,      0,      0,      0,  12869,      0,    65, 0, 0, 0, 0},
    '{0,      0,      0,      0,      0,      0,      0,      0,  12869,    65, 0, 0, 0, 0},
    '{0,    100,    200,    300,   -100,   -200,   -300,  16383, -16384,   700, 0, 0, 0, 0},
    '{1,   5000,   5000,  -5000,   5000,   5000,  -5000,   5000,  -5000,  5000, 1, 0, 0, 0},
    '{0,    500,      0,      0,    500,      0,      0,    100,      0,     1, 0, 0, 0, 0},
    '{0,   -500,      0,      0,   -500,      0,      0,   -100,      0,     0, 0, 0, 0, 0},
    '{0,  32767,  32767, -32768, -32768, -32768,  32767,      0,      0, 32768, 0, 0, 0, 0},
    '{0,   4096,  -4096,      1,      0,      1,     -1,      1,     -1,  1000, 0, 0, 0, 0},
    '{0,     -1,     -1,     -1,      1,      1,      1,     -1,      1, 65535, 0, 0, 0, 0}
  };

  three_axis_pid_with_heading_wrap DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clamp(longint x, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic int srnd(int mag);
    return int'($urandom_range(2 * mag)) - mag;
  endfunction

  function automatic logic signed [DRIVE_W-1:0] axis_drive(int ax, longint err, longint dt);
    longint kp, ki, kd, e, rate, acc;
    kp = longint'($signed(gain_reg[ax][15:0]));
    ki = longint'($signed(gain_reg[ax][31:16]));
    kd = longint'($signed(gain_reg[ax][47:32]));
    e  = clamp(err, ANGLE_BITS);
    integ[ax] = clamp(integ[ax] + ((e * dt) >>> 16), INTEGRAL_BITS);
    // truncating divide, same as the hardware quotient
    rate = clamp(((e - prev_err[ax]) * 65536) / dt, DERIV_BITS);
    prev_err[ax] = e;
    acc = kp * e + ki * integ[ax] + kd * rate;
    return DRIVE_W'(clamp(acc >>> 12, DRIVE_W));
  endfunction

  function automatic drives_t tick_drives(tick_fields_t f, bit clr);
    longint  dt, yaw_err;
    drives_t d;
    if (clr) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        integ[a]    = 0;
        prev_err[a] = 0;
      end
      return '0;
    end
    dt = (f.interval == 0) ? 1 : longint'(f.interval);
    yaw_err = longint'($signed(f.head_target)) - longint'($signed(f.head_sensed));
    if (yaw_err > longint'(Q_PI)) yaw_err -= longint'(Q_TWO_PI);
    else if (yaw_err < -longint'(Q_PI)) yaw_err += longint'(Q_TWO_PI);
    d.roll  = axis_drive(AX_ROLL, longint'($signed(f.roll_radio))
                + longint'($signed(f.roll_host)) - longint'($signed(f.roll_sensed)), dt);
    d.pitch = axis_drive(AX_PITCH, longint'($signed(f.pitch_radio))
                + longint'($signed(f.pitch_host)) - longint'($signed(f.pitch_sensed)), dt);
    d.yaw   = axis_drive(AX_YAW, yaw_err, dt);
    return d;
  endfunction

  function automatic tick_fields_t mk_tick(int rr, rh, rs, pr, ph, ps, ht, hs, dt);
    tick_fields_t f;
    f.roll_radio   = 16'(rr);
    f.roll_host    = 16'(rh);
    f.roll_sensed  = 16'(rs);
    f.pitch_radio  = 16'(pr);
    f.pitch_host   = 16'(ph);
    f.pitch_sensed = 16'(ps);
    f.head_target  = 15'(ht);
    f.head_sensed  = 15'(hs);
    f.interval     = 16'(dt);
    return f;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_tick(tick_fields_t f, bit clr, bit typed, drives_t typed_drives);
    drives_t d;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, f};
    s_axis_tuser  <= clr;
    do @(posedge clk_i); while (!s_axis_tready);
    d = tick_drives(f, clr);
    pending_drives.push_back(typed ? typed_drives : d);
    @(negedge clk_i);
  endtask

  task automatic write_gain(logic [1:0] idx, logic [GAIN_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_GAINS_ROLL:  gain_reg[AX_ROLL]  = val;
      REG_GAINS_PITCH: gain_reg[AX_PITCH] = val;
      REG_GAINS_YAW:   gain_reg[AX_YAW]   = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(int idle, int stall, gain_style_e style, int count);
    logic [1:0]        axis_reg [NUM_AXES];
    logic [GAIN_W-1:0] g;
    logic [159:0]      raw;
    tick_fields_t      f;
    int                pick;
    bit                clr;
    axis_reg = '{REG_GAINS_ROLL, REG_GAINS_PITCH, REG_GAINS_YAW};
    wait_drained();
    for (int a = 0; a < NUM_AXES; a++) begin
      case (style)
        GAINS_EXTREME: begin
          g = (a == AX_ROLL) ? 48'h7FFF_7FFF_7FFF :
              (a == AX_PITCH) ? 48'h8000_8000_8000 : 48'hFFFF_FFFF_FFFF;
        end
        GAINS_RANDOM: g = GAIN_W'({$urandom, $urandom});
        GAINS_SMALL:  g = {16'(srnd(512)), 16'(srnd(512)), 16'(srnd(512))};
        default:      g = {16'(srnd(64)), 16'(srnd(32)), 16'h0100};
      endcase
      write_gain(axis_reg[a], g);
    end
    write_gain(REG_NONE, GAIN_W'({$urandom, $urandom}));
    cfg_we_i  <= 1'b0;
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      clr  = (pick < 4);
      if (pick < 75) begin
        // plausible flight data: small commands, headings within +-pi
        f = mk_tick(srnd(4096), srnd(1024), srnd(8192), srnd(4096), srnd(1024), srnd(8192),
                    srnd(12868), srnd(12868),
                    ($urandom_range(9) == 0) ? 0 : $urandom_range(8192, 1));
      end else begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        f   = raw[141:0];
      end
      push_tick(f, clr, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    drives_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_drives.size() == 0) begin
        $error("result with no request pending: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_drives.pop_front();
        for (int a = 0; a < NUM_AXES; a++) begin
          if (got[a*DRIVE_W +: DRIVE_W] !== want[a*DRIVE_W +: DRIVE_W]) begin
            $error("%s: expected %0d, got %0d", axis_name[a],
                   $signed(want[a*DRIVE_W +: DRIVE_W]), $signed(got[a*DRIVE_W +: DRIVE_W]));
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_CYCLES) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t r;
    drives_t  want;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < NUM_DIR; i++) begin
      if (i == FIRST_GAINED_ROW) begin
        wait_drained();
        write_gain(REG_GAINS_ROLL,  48'h0020_0080_0200);
        write_gain(REG_GAINS_PITCH, 48'hFFE0_FF80_FE00);
        write_gain(REG_GAINS_YAW,   48'h0010_0040_0300);
        cfg_we_i <= 1'b0;
      end
      r = dir_table[i];
      want.roll  = 16'(r.w_roll);
      want.pitch = 16'(r.w_pitch);
      want.yaw   = 16'(r.w_yaw);
      push_tick(mk_tick(r.rr, r.rh, r.rs, r.pr, r.ph, r.ps, r.ht, r.hs, r.dt),
                r.clr, r.typed, want);
    end
    run_phase(0, 0, GAINS_EXTREME, 160);
    run_phase(65, 0, GAINS_RANDOM, 160);
    run_phase(0, 65, GAINS_SMALL, 170);
    run_phase(6, 6, GAINS_UNITY, 160);
    wait_drained();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== three_axis_pid_with_heading_wrap.f =====
rtl/pid3_pkg.sv
rtl/pid3_lane.sv
rtl/pid3_merge.sv
rtl/three_axis_pid_with_heading_wrap.sv
rtl/pid3_checker.sv
sim/tb_top.sv
